// ----- hw/rtl/dvc_pkg.sv -----
// Package for the differential vector clock block.
// Holds sizes, operation codes, sequencer states and the transaction structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvc_pkg;

	localparam int PROCESS_COUNT = 16;
	localparam int IDX_W = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
	localparam int DEPTH = 1 << IDX_W;
	localparam int FIELD_IDX_W = 4;
	localparam int SCAN_LIMIT = (PROCESS_COUNT < 16) ? PROCESS_COUNT : 16;
	localparam logic [FIELD_IDX_W-1:0] SCAN_LAST = FIELD_IDX_W'(SCAN_LIMIT - 1);
	localparam int CLK_W = 32;
	localparam logic [CLK_W-1:0] CLOCK_MAX = '1;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	typedef enum logic [1:0] {
		OP_INTERNAL    = 2'd0,
		OP_SEND        = 2'd1,
		OP_RECV_BEGIN  = 2'd2,
		OP_RECV_ENTRY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_OWN,
		B_TICK,
		B_RX_RD,
		B_RX_WR,
		B_LS,
		B_SCAN,
		B_FIN
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] dest_addr;
		logic             dest_ok;
		logic [IDX_W-1:0] entry_addr;
		logic             entry_ok;
		logic [CLK_W-1:0] entry_value;
	} item_t;

	typedef struct packed {
		logic                   has_entry;
		logic [FIELD_IDX_W-1:0] index;
		logic [CLK_W-1:0]       value;
		logic [CLK_W-1:0]       own;
		logic                   last;
	} result_t;

	function automatic logic idx_ok(input logic [FIELD_IDX_W-1:0] idx);
		return int'(idx) < PROCESS_COUNT;
	endfunction

	function automatic logic [IDX_W-1:0] to_addr(input logic [FIELD_IDX_W-1:0] idx);
		return IDX_W'(idx);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dvc_front.sv -----
// Front end of the differential vector clock: accepts and classifies commands.
// Decodes the operation and range-checks indexes; uses dvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvc_front (
	input  wire logic                                 start,
	input  wire logic [1:0]                           op,
	input  wire logic [dvc_pkg::FIELD_IDX_W-1:0]      dest_index,
	input  wire logic [dvc_pkg::FIELD_IDX_W-1:0]      entry_index,
	input  wire logic [dvc_pkg::CLK_W-1:0]            entry_value,
	input  wire logic                                 full,
	output logic                                      busy,
	output logic                                      push,
	output dvc_pkg::item_t                            item
);

	always_comb begin
		busy = full;
		push = start && !full;
		item.op = dvc_pkg::op_t'(op);
		item.dest_addr = dvc_pkg::to_addr(dest_index);
		item.dest_ok = dvc_pkg::idx_ok(dest_index);
		item.entry_addr = dvc_pkg::to_addr(entry_index);
		item.entry_ok = dvc_pkg::idx_ok(entry_index);
		item.entry_value = entry_value;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dvc_queue.sv -----
// Short command queue between front end and back end.
// Holds classified transactions; uses dvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dvc_pkg::item_t push_item,
	input  wire logic           pop,
	output dvc_pkg::item_t      pop_item,
	output logic                full,
	output logic                empty
);

	dvc_pkg::item_t           slot_q [dvc_pkg::QDEPTH];
	logic [dvc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dvc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dvc_pkg::QPTR_W:0]   count_q;

	always_comb begin
		full = (count_q == (dvc_pkg::QPTR_W + 1)'(dvc_pkg::QDEPTH));
		empty = (count_q == '0);
		pop_item = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dvc_back.sv -----
// Back end of the differential vector clock: sequencer and clock tables.
// Runs ticks, receives and send scans; uses dvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvc_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [dvc_pkg::FIELD_IDX_W-1:0]  self_index,
	input  wire logic                             empty,
	input  wire dvc_pkg::item_t                   head,
	output logic                                  pop,
	output logic                                  strobe,
	output dvc_pkg::result_t                      result
);

	dvc_pkg::back_state_t state_q, state_d;
	dvc_pkg::item_t       item_q, item_d;
	logic [dvc_pkg::CLK_W-1:0] own_q, own_d;
	logic [dvc_pkg::CLK_W-1:0] ls_q, ls_d;
	logic [dvc_pkg::FIELD_IDX_W-1:0] cnt_q, cnt_d;
	logic                      pend_q, pend_d;
	logic [dvc_pkg::FIELD_IDX_W-1:0] pend_idx_q, pend_idx_d;
	logic [dvc_pkg::CLK_W-1:0] pend_val_q, pend_val_d;

	logic [dvc_pkg::CLK_W-1:0] clk_mem [dvc_pkg::DEPTH];
	logic [dvc_pkg::CLK_W-1:0] lu_mem  [dvc_pkg::DEPTH];
	logic [dvc_pkg::CLK_W-1:0] ls_mem  [dvc_pkg::DEPTH];
	logic [dvc_pkg::DEPTH-1:0] clk_vld_q, lu_vld_q, ls_vld_q;
	logic [dvc_pkg::CLK_W-1:0] clk_rd_q, lu_rd_q, ls_rd_q;
	logic                      clk_rv_q, lu_rv_q, ls_rv_q;
	logic [dvc_pkg::CLK_W-1:0] clk_data, lu_data, ls_data;

	logic [dvc_pkg::IDX_W-1:0] clk_raddr, lu_raddr, ls_raddr;
	logic                      clk_we, lu_we, ls_we;
	logic [dvc_pkg::IDX_W-1:0] clk_waddr, lu_waddr, ls_waddr;
	logic [dvc_pkg::CLK_W-1:0] clk_wdata, lu_wdata, ls_wdata;

	logic                      emit;
	dvc_pkg::result_t          res_d;
	logic                      strobe_q;
	dvc_pkg::result_t          result_q;

	logic                      self_ok;
	logic [dvc_pkg::IDX_W-1:0] self_addr;
	logic [dvc_pkg::CLK_W-1:0] tick_val;
	logic                      raise;
	logic                      hit;

	always_comb begin
		clk_data = clk_rv_q ? clk_rd_q : '0;
		lu_data = lu_rv_q ? lu_rd_q : '0;
		ls_data = ls_rv_q ? ls_rd_q : '0;
		self_ok = dvc_pkg::idx_ok(self_index);
		self_addr = dvc_pkg::to_addr(self_index);
	end

	always_comb begin
		state_d = state_q;
		item_d = item_q;
		own_d = own_q;
		ls_d = ls_q;
		cnt_d = cnt_q;
		pend_d = pend_q;
		pend_idx_d = pend_idx_q;
		pend_val_d = pend_val_q;
		pop = 1'b0;
		clk_raddr = self_addr;
		lu_raddr = dvc_pkg::to_addr(cnt_q);
		ls_raddr = item_q.dest_addr;
		clk_we = 1'b0;
		lu_we = 1'b0;
		ls_we = 1'b0;
		clk_waddr = self_addr;
		lu_waddr = self_addr;
		ls_waddr = item_q.dest_addr;
		clk_wdata = '0;
		lu_wdata = '0;
		ls_wdata = own_q;
		emit = 1'b0;
		res_d = '0;
		tick_val = (clk_data == dvc_pkg::CLOCK_MAX) ? clk_data : clk_data + 1'b1;
		raise = item_q.entry_ok && (clk_data < item_q.entry_value);
		hit = lu_data > ls_q;

		case (state_q)
			dvc_pkg::B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					item_d = head;
					state_d = dvc_pkg::B_OWN;
				end
			end
			dvc_pkg::B_OWN: begin
				if (item_q.op == dvc_pkg::OP_RECV_ENTRY) begin
					state_d = dvc_pkg::B_RX_RD;
				end else begin
					state_d = dvc_pkg::B_TICK;
				end
			end
			dvc_pkg::B_TICK: begin
				clk_we = self_ok;
				lu_we = self_ok;
				clk_wdata = tick_val;
				lu_wdata = tick_val;
				own_d = self_ok ? tick_val : '0;
				cnt_d = '0;
				pend_d = 1'b0;
				if (item_q.op == dvc_pkg::OP_SEND) begin
					state_d = dvc_pkg::B_LS;
				end else begin
					emit = 1'b1;
					res_d.own = self_ok ? tick_val : '0;
					res_d.last = 1'b1;
					state_d = dvc_pkg::B_IDLE;
				end
			end
			dvc_pkg::B_RX_RD: begin
				own_d = self_ok ? clk_data : '0;
				clk_raddr = item_q.entry_addr;
				state_d = dvc_pkg::B_RX_WR;
			end
			dvc_pkg::B_RX_WR: begin
				clk_waddr = item_q.entry_addr;
				lu_waddr = item_q.entry_addr;
				clk_we = raise;
				lu_we = raise;
				clk_wdata = item_q.entry_value;
				emit = 1'b1;
				res_d.last = 1'b1;
				if (raise && self_ok && (item_q.entry_addr == self_addr)) begin
					lu_wdata = item_q.entry_value;
					res_d.own = item_q.entry_value;
				end else begin
					lu_wdata = own_q;
					res_d.own = own_q;
				end
				state_d = dvc_pkg::B_IDLE;
			end
			dvc_pkg::B_LS: begin
				ls_d = item_q.dest_ok ? ls_data : '0;
				clk_raddr = dvc_pkg::to_addr(cnt_q);
				lu_raddr = dvc_pkg::to_addr(cnt_q);
				state_d = dvc_pkg::B_SCAN;
			end
			dvc_pkg::B_SCAN: begin
				clk_raddr = dvc_pkg::to_addr(cnt_q + 1'b1);
				lu_raddr = dvc_pkg::to_addr(cnt_q + 1'b1);
				if (hit) begin
					if (pend_q) begin
						emit = 1'b1;
						res_d.has_entry = 1'b1;
						res_d.index = pend_idx_q;
						res_d.value = pend_val_q;
						res_d.own = own_q;
					end
					pend_d = 1'b1;
					pend_idx_d = cnt_q;
					pend_val_d = clk_data;
				end
				if (cnt_q == dvc_pkg::SCAN_LAST) begin
					state_d = dvc_pkg::B_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			dvc_pkg::B_FIN: begin
				ls_we = item_q.dest_ok;
				emit = 1'b1;
				res_d.has_entry = pend_q;
				res_d.index = pend_q ? pend_idx_q : '0;
				res_d.value = pend_q ? pend_val_q : '0;
				res_d.own = own_q;
				res_d.last = 1'b1;
				state_d = dvc_pkg::B_IDLE;
			end
			default: begin
				state_d = dvc_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvc_pkg::B_IDLE;
			strobe_q <= 1'b0;
			clk_vld_q <= '0;
			lu_vld_q <= '0;
			ls_vld_q <= '0;
		end else begin
			state_q <= state_d;
			strobe_q <= emit;
			if (clk_we) begin
				clk_vld_q[clk_waddr] <= 1'b1;
			end
			if (lu_we) begin
				lu_vld_q[lu_waddr] <= 1'b1;
			end
			if (ls_we) begin
				ls_vld_q[ls_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		own_q <= own_d;
		ls_q <= ls_d;
		cnt_q <= cnt_d;
		pend_q <= pend_d;
		pend_idx_q <= pend_idx_d;
		pend_val_q <= pend_val_d;
		result_q <= res_d;
		if (clk_we) begin
			clk_mem[clk_waddr] <= clk_wdata;
		end
		if (lu_we) begin
			lu_mem[lu_waddr] <= lu_wdata;
		end
		if (ls_we) begin
			ls_mem[ls_waddr] <= ls_wdata;
		end
		clk_rd_q <= clk_mem[clk_raddr];
		clk_rv_q <= clk_vld_q[clk_raddr];
		lu_rd_q <= lu_mem[lu_raddr];
		lu_rv_q <= lu_vld_q[lu_raddr];
		ls_rd_q <= ls_mem[ls_raddr];
		ls_rv_q <= ls_vld_q[ls_raddr];
	end

	always_comb begin
		strobe = strobe_q;
		result = result_q;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/differential_vector_clock.sv -----
// Differential vector clock for one process: top level.
// Holds the self-index register; instantiates dvc_front, dvc_queue and dvc_back.
//
// Usage:
//   Commands enter on start/op/dest_index/entry_index/entry_value; a transaction
//   is taken at a clock edge with start high and busy low. A two-entry queue
//   sits between the decoder and the sequencer, so up to two commands can wait
//   while one is carried out; busy is high only while the queue is full.
//   Results leave on has_entry/out_index/out_value/own_clock/last, each valid
//   for exactly one cycle while strobe is high; the receiver cannot stall, so
//   every result is taken when it appears. last marks the final result of a
//   command.
//   Sequencer states per command (one table read port per table): internal
//   event and receive begin pass IDLE, OWN, TICK; receive entry IDLE, OWN,
//   RX_RD, RX_WR; send IDLE, OWN, TICK, LS, SCAN over min(PROCESS_COUNT, 16)
//   entries at one entry per cycle, then FIN; each result is registered.
//   Reset clears all three tables through per-entry valid bits at once and
//   sets self_index to 0; no clearing pass is needed.
//   Write self_index through cfg_we/cfg_wdata only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module differential_vector_clock (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        op,
	input  wire logic [dvc_pkg::FIELD_IDX_W-1:0]   dest_index,
	input  wire logic [dvc_pkg::FIELD_IDX_W-1:0]   entry_index,
	input  wire logic [dvc_pkg::CLK_W-1:0]         entry_value,
	input  wire logic                              cfg_we,
	input  wire logic [dvc_pkg::FIELD_IDX_W-1:0]   cfg_wdata,
	output logic                                   strobe,
	output logic                                   has_entry,
	output logic [dvc_pkg::FIELD_IDX_W-1:0]        out_index,
	output logic [dvc_pkg::CLK_W-1:0]              out_value,
	output logic [dvc_pkg::CLK_W-1:0]              own_clock,
	output logic                                   last
);

	logic [dvc_pkg::FIELD_IDX_W-1:0] self_index_q;
	logic                            push;
	dvc_pkg::item_t                  push_item;
	dvc_pkg::item_t                  head;
	logic                            full;
	logic                            empty;
	logic                            pop;
	dvc_pkg::result_t                result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_index_q <= '0;
		end else if (cfg_we) begin
			self_index_q <= cfg_wdata;
		end
	end

	dvc_front u_front (
		.start       (start),
		.op          (op),
		.dest_index  (dest_index),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.full        (full),
		.busy        (busy),
		.push        (push),
		.item        (push_item)
	);

	dvc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (head),
		.full      (full),
		.empty     (empty)
	);

	dvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.self_index (self_index_q),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.strobe     (strobe),
		.result     (result)
	);

	always_comb begin
		has_entry = result.has_entry;
		out_index = result.index;
		out_value = result.value;
		own_clock = result.own;
		last = result.last;
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking bench for differential_vector_clock: queue-fed command driver,
// result monitor, and a vector clock model that predicts every result.
// Depends on dvc_pkg and the differential_vector_clock RTL.
`timescale 1ns / 1ps

module tb;
	import dvc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		op_t                    op;
		logic [FIELD_IDX_W-1:0] dest;
		logic [FIELD_IDX_W-1:0] entry_idx;
		logic [CLK_W-1:0]       entry_val;
	} vc_cmd_t;

	typedef struct packed {
		logic                   has_entry;
		logic [FIELD_IDX_W-1:0] index;
		logic [CLK_W-1:0]       value;
		logic [CLK_W-1:0]       own;
		logic                   last;
	} vc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = '0;
	logic [FIELD_IDX_W-1:0] dest_index = '0;
	logic [FIELD_IDX_W-1:0] entry_index = '0;
	logic [CLK_W-1:0] entry_value = '0;
	logic cfg_we = 1'b0;
	logic [FIELD_IDX_W-1:0] cfg_wdata = '0;
	logic busy;
	logic strobe;
	logic has_entry;
	logic [FIELD_IDX_W-1:0] out_index;
	logic [CLK_W-1:0] out_value;
	logic [CLK_W-1:0] own_clock;
	logic last;

	vc_cmd_t pending_cmds[$];
	vc_cmd_t cur_cmd;
	vc_result_t results_due[$];

	logic [CLK_W-1:0] vclock [PROCESS_COUNT] = '{default: '0};
	logic [CLK_W-1:0] updated_at [PROCESS_COUNT] = '{default: '0};
	logic [CLK_W-1:0] sent_at [PROCESS_COUNT] = '{default: '0};
	logic [FIELD_IDX_W-1:0] self_idx = '0;

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int gap_left = 0;
	bit idle_enable = 1'b0;
	bit bursty = 1'b1;

	always #5 clk = ~clk;

	differential_vector_clock i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.dest_index(dest_index),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.strobe(strobe),
		.has_entry(has_entry),
		.out_index(out_index),
		.out_value(out_value),
		.own_clock(own_clock),
		.last(last)
	);

	function automatic logic [CLK_W-1:0] own_clock_value();
		if (int'(self_idx) < PROCESS_COUNT)
			return vclock[self_idx];
		return '0;
	endfunction

	task automatic tick_own();
		logic [CLK_W-1:0] c;
		if (int'(self_idx) < PROCESS_COUNT) begin
			c = vclock[self_idx];
			if (c != CLOCK_MAX)
				c = c + 1'b1;
			vclock[self_idx] = c;
			updated_at[self_idx] = c;
		end
	endtask

	task automatic vc_update(input vc_cmd_t cmd);
		logic [CLK_W-1:0] sent_mark;
		int hits;
		int k;
		hits = 0;
		k = 0;
		case (cmd.op)
			OP_INTERNAL, OP_RECV_BEGIN: begin
				tick_own();
			end
			OP_RECV_ENTRY: begin
				if (int'(cmd.entry_idx) < PROCESS_COUNT &&
					vclock[cmd.entry_idx] < cmd.entry_val) begin
					vclock[cmd.entry_idx] = cmd.entry_val;
					updated_at[cmd.entry_idx] = own_clock_value();
				end
			end
			default: begin
				tick_own();
				sent_mark = (int'(cmd.dest) < PROCESS_COUNT) ? sent_at[cmd.dest] : '0;
				for (int i = 0; i < SCAN_LIMIT; i++)
					if (updated_at[i] > sent_mark)
						hits++;
				for (int i = 0; i < SCAN_LIMIT; i++) begin
					if (updated_at[i] > sent_mark) begin
						k++;
						results_due.insert(results_due.size(),
							vc_result_t'({1'b1, FIELD_IDX_W'(i), vclock[i],
							own_clock_value(), k == hits}));
					end
				end
				if (int'(cmd.dest) < PROCESS_COUNT)
					sent_at[cmd.dest] = own_clock_value();
			end
		endcase
		if (hits == 0)
			results_due.insert(results_due.size(),
				vc_result_t'({1'b0, FIELD_IDX_W'(0), CLK_W'(0),
				own_clock_value(), 1'b1}));
	endtask

	always @(posedge clk) begin : driver
		if (arst_n) begin
			if (start && !busy) begin
				vc_update(cur_cmd);
				if (idle_enable && bursty && $urandom_range(0, 2) == 0)
					gap_left = $urandom_range(1, 15);
				if ($urandom_range(0, 31) == 0)
					bursty = !bursty;
			end
			if (!start || !busy) begin
				if (gap_left == 0 && pending_cmds.size() != 0) begin
					cur_cmd = pending_cmds.pop_front();
					start <= 1'b1;
					op <= cur_cmd.op;
					dest_index <= cur_cmd.dest;
					entry_index <= cur_cmd.entry_idx;
					entry_value <= cur_cmd.entry_val;
				end else begin
					start <= 1'b0;
					if (gap_left != 0)
						gap_left = gap_left - 1;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		vc_result_t got;
		vc_result_t want;
		if (arst_n && strobe) begin
			got = {has_entry, out_index, out_value, own_clock, last};
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: has %0d idx %0d val %h own %h last %0d",
						got.has_entry, got.index, got.value, got.own, got.last);
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp/act has %0d/%0d idx %0d/%0d val %h/%h own %h/%h last %0d/%0d",
							want.has_entry, got.has_entry, want.index, got.index,
							want.value, got.value, want.own, got.own, want.last, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic add_item(input op_t cmd_op, input logic [FIELD_IDX_W-1:0] dest,
		input logic [FIELD_IDX_W-1:0] idx, input logic [CLK_W-1:0] val);
		pending_cmds.insert(pending_cmds.size(), vc_cmd_t'({cmd_op, dest, idx, val}));
	endtask

	function automatic logic [FIELD_IDX_W-1:0] rand_idx();
		return FIELD_IDX_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [CLK_W-1:0] rand_value();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return CLK_W'($urandom_range(0, 300));
	endfunction

	task automatic add_random_traffic(input int count);
		int added;
		int kind;
		int n;
		logic [FIELD_IDX_W-1:0] dest;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				add_item(OP_RECV_BEGIN, rand_idx(), rand_idx(), $urandom);
				n = $urandom_range(1, 4);
				repeat (n)
					add_item(OP_RECV_ENTRY, rand_idx(), rand_idx(), rand_value());
				added += n + 1;
			end else if (kind < 8) begin
				dest = ($urandom_range(0, 1) == 0) ?
					FIELD_IDX_W'($urandom_range(0, 3)) : rand_idx();
				add_item(OP_SEND, dest, rand_idx(), $urandom);
				added++;
			end else if (kind == 8) begin
				add_item(OP_INTERNAL, rand_idx(), rand_idx(), $urandom);
				added++;
			end else begin
				add_item(op_t'(2'($urandom_range(0, 3))), rand_idx(), rand_idx(), rand_value());
				added++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || start || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_self_index(input logic [FIELD_IDX_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		self_idx = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [FIELD_IDX_W-1:0] phase_self [8];
		phase_self = '{4'd15, 4'd0, 4'd0, 4'd0, 4'd7, 4'd15, 4'd0, 4'd0};
		phase_self[2] = rand_idx();
		phase_self[3] = rand_idx();
		phase_self[6] = rand_idx();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_enable = 1'b1;

		add_item(OP_INTERNAL, 4'd0, 4'd0, 32'd0);
		add_item(OP_RECV_BEGIN, 4'd15, 4'd15, 32'hFFFF_FFFF);
		add_item(OP_RECV_ENTRY, 4'd0, 4'd4, 32'd10);
		add_item(OP_RECV_ENTRY, 4'd0, 4'd4, 32'd5);
		add_item(OP_RECV_ENTRY, 4'd0, 4'd4, 32'd10);
		add_item(OP_RECV_ENTRY, 4'd15, 4'd15, 32'hFFFF_FFFF);
		add_item(OP_RECV_ENTRY, 4'd0, 4'd0, 32'd0);
		add_item(OP_SEND, 4'd0, 4'd0, 32'd0);
		add_item(OP_SEND, 4'd15, 4'd0, 32'd0);
		add_item(OP_SEND, 4'd15, 4'd0, 32'd0);
		add_item(OP_SEND, 4'd4, 4'd15, 32'hFFFF_FFFF);
		add_item(OP_RECV_ENTRY, 4'd0, 4'd7, 32'hA5A5_A5A5);
		add_item(OP_SEND, 4'd15, 4'd0, 32'd0);
		add_item(OP_INTERNAL, 4'd15, 4'd15, 32'hFFFF_FFFF);
		wait_drained();

		// drive the own entry into saturation, then send with nothing new
		write_self_index(4'd9);
		add_item(OP_RECV_ENTRY, 4'd0, 4'd9, 32'hFFFF_FFFE);
		add_item(OP_INTERNAL, 4'd0, 4'd0, 32'd0);
		add_item(OP_INTERNAL, 4'd0, 4'd0, 32'd0);
		add_item(OP_SEND, 4'd2, 4'd0, 32'd0);
		add_item(OP_SEND, 4'd2, 4'd0, 32'd0);
		add_item(OP_RECV_BEGIN, 4'd0, 4'd0, 32'd0);
		add_item(OP_SEND, 4'd2, 4'd0, 32'd0);
		add_item(OP_RECV_ENTRY, 4'd0, 4'd9, 32'hFFFF_FFFF);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_self_index(phase_self[p]);
			if (p == 7)
				idle_enable = 1'b0;
			add_random_traffic(44);
			wait_drained();
		end

		if (mismatches == 0 && results_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
